[src/assert_macros.svh]
// Assertion helper macros for the complex ALU.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with synchronous reset masking.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Two conditions that must never hold together.
`define ASSERT_NEVER_BOTH(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) !((a) && (b))) \
      else $error("mutually exclusive conditions seen together");

`endif

[src/cna_pkg.sv]
// Shared types and operation codes for the complex ALU.
// No dependencies.
package cna_pkg;

   localparam int FIELD_W = 32;
   localparam int OP_W    = 4;

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_ADD = op_type'(0);
   localparam op_type OP_SUB = op_type'(1);
   localparam op_type OP_MUL = op_type'(2);
   localparam op_type OP_DIV = op_type'(3);
   localparam op_type OP_MAG = op_type'(4);
   localparam op_type OP_LT  = op_type'(5);
   localparam op_type OP_LE  = op_type'(6);
   localparam op_type OP_GT  = op_type'(7);
   localparam op_type OP_GE  = op_type'(8);
   localparam op_type OP_EQ  = op_type'(9);
   localparam op_type OP_NE  = op_type'(10);

   // control that rides along with each item through the pipe
   typedef struct packed {
      op_type op;
      logic   neg_re;
      logic   neg_im;
      logic   huge_re;
      logic   huge_im;
      logic   dz;
      logic   cmp;
   } ctl_type;

endpackage

[src/cna_req_if.sv]
// Request channel of the complex ALU: operation code and two complex operands.
// Depends on cna_pkg.
interface cna_req_if;
   logic                                valid;
   logic                                ready;
   logic [cna_pkg::OP_W-1:0]            operation;
   logic signed [cna_pkg::FIELD_W-1:0]  a_re;
   logic signed [cna_pkg::FIELD_W-1:0]  a_im;
   logic signed [cna_pkg::FIELD_W-1:0]  b_re;
   logic signed [cna_pkg::FIELD_W-1:0]  b_im;

   modport source (output valid, operation, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, operation, a_re, a_im, b_re, b_im, output ready);
endinterface

[src/cna_rsp_if.sv]
// Response channel of the complex ALU: complex result, magnitude and flags.
// Depends on cna_pkg.
interface cna_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [cna_pkg::FIELD_W-1:0]  res_re;
   logic signed [cna_pkg::FIELD_W-1:0]  res_im;
   logic [cna_pkg::FIELD_W-1:0]         magnitude;
   logic                                compare_true;
   logic                                divide_by_zero;
   logic                                saturated;

   modport source (output valid, res_re, res_im, magnitude, compare_true,
                   divide_by_zero, saturated, input ready);
   modport sink   (input valid, res_re, res_im, magnitude, compare_true,
                   divide_by_zero, saturated, output ready);
endinterface

[src/cna_front.sv]
// Front end of the complex ALU: products, sums, squared magnitudes, compares
// and divider setup over three register stages. Depends on cna_pkg, cna_req_if.
module cna_front #(
   parameter int DW = 32,
   parameter int F  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   cna_req_if.sink              req,
   output logic                 out_valid,
   input  logic                 out_ready,
   output cna_pkg::ctl_type     out_ctl,
   output logic [2*DW+F+DW+1:0] out_rem_re,
   output logic [2*DW+F+DW+1:0] out_rem_im,
   output logic [DW:0]          out_val_re,
   output logic [DW:0]          out_val_im,
   output logic [2*DW-1:0]      out_d,
   output logic [2*DW-1:0]      out_srem
);
   localparam int PW = 2 * DW;
   localparam int CW = PW + F + DW + 2;

   // ---------------- stage 1: multipliers ----------------
   logic signed [DW-1:0] ar, ai, br, bi;
   logic                 is_sub;
   logic                 en1, en2, en3;

   logic                 v1_ff;
   cna_pkg::op_type      op1_ff;
   logic                 eq1_ff, eq1_in;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [PW-1:0] q_aa_ff, q_ai_ff, q_bb_ff, q_bi_ff;
   logic signed [PW-1:0] p_rr_in, p_ii_in, p_ri_in, p_ir_in;
   logic signed [PW-1:0] q_aa_in, q_ai_in, q_bb_in, q_bi_in;
   logic signed [DW:0]   s_re_ff, s_im_ff, s_re_in, s_im_in;

   assign ar = $signed(req.a_re[DW-1:0]);
   assign ai = $signed(req.a_im[DW-1:0]);
   assign br = $signed(req.b_re[DW-1:0]);
   assign bi = $signed(req.b_im[DW-1:0]);
   assign is_sub = (req.operation == cna_pkg::OP_SUB);

   always_comb begin
      p_rr_in = ar * br;
      p_ii_in = ai * bi;
      p_ri_in = ar * bi;
      p_ir_in = ai * br;
      q_aa_in = ar * ar;
      q_ai_in = ai * ai;
      q_bb_in = br * br;
      q_bi_in = bi * bi;
      eq1_in  = (ar == br) && (ai == bi);
      if (is_sub) begin
         s_re_in = $signed({ar[DW-1], ar}) - $signed({br[DW-1], br});
         s_im_in = $signed({ai[DW-1], ai}) - $signed({bi[DW-1], bi});
      end else begin
         s_re_in = $signed({ar[DW-1], ar}) + $signed({br[DW-1], br});
         s_im_in = $signed({ai[DW-1], ai}) + $signed({bi[DW-1], bi});
      end
   end

   assign en1       = !v1_ff || en2;
   assign req.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         op1_ff  <= req.operation;
         eq1_ff  <= eq1_in;
         p_rr_ff <= p_rr_in;
         p_ii_ff <= p_ii_in;
         p_ri_ff <= p_ri_in;
         p_ir_ff <= p_ir_in;
         q_aa_ff <= q_aa_in;
         q_ai_ff <= q_ai_in;
         q_bb_ff <= q_bb_in;
         q_bi_ff <= q_bi_in;
         s_re_ff <= s_re_in;
         s_im_ff <= s_im_in;
      end
   end

   // ---------------- stage 2: sums and sign/magnitude ----------------
   logic signed [PW:0]   e_rr, e_ii, e_ri, e_ir, x_re, x_im;
   logic [PW:0]          ax_re, ax_im;
   logic                 v2_ff;
   cna_pkg::op_type      op2_ff;
   logic                 eq2_ff;
   logic                 neg_re2_ff, neg_im2_ff;
   logic [PW-1:0]        mag_re2_ff, mag_im2_ff, mag_re2_in, mag_im2_in;
   logic [PW-1:0]        sqa2_ff, sqb2_ff, sqa2_in, sqb2_in;

   assign e_rr = $signed({p_rr_ff[PW-1], p_rr_ff});
   assign e_ii = $signed({p_ii_ff[PW-1], p_ii_ff});
   assign e_ri = $signed({p_ri_ff[PW-1], p_ri_ff});
   assign e_ir = $signed({p_ir_ff[PW-1], p_ir_ff});

   always_comb begin
      if (op1_ff == cna_pkg::OP_ADD || op1_ff == cna_pkg::OP_SUB) begin
         x_re = $signed({{(PW-DW){s_re_ff[DW]}}, s_re_ff});
         x_im = $signed({{(PW-DW){s_im_ff[DW]}}, s_im_ff});
      end else if (op1_ff == cna_pkg::OP_DIV) begin
         // a * conj(b)
         x_re = e_rr + e_ii;
         x_im = e_ir - e_ri;
      end else begin
         x_re = e_rr - e_ii;
         x_im = e_ri + e_ir;
      end
      ax_re      = x_re[PW] ? -x_re : x_re;
      ax_im      = x_im[PW] ? -x_im : x_im;
      mag_re2_in = ax_re[PW-1:0];
      mag_im2_in = ax_im[PW-1:0];
      sqa2_in    = q_aa_ff + q_ai_ff;
      sqb2_in    = q_bb_ff + q_bi_ff;
   end

   assign en2 = !v2_ff || en3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         op2_ff     <= op1_ff;
         eq2_ff     <= eq1_ff;
         neg_re2_ff <= x_re[PW];
         neg_im2_ff <= x_im[PW];
         mag_re2_ff <= mag_re2_in;
         mag_im2_ff <= mag_im2_in;
         sqa2_ff    <= sqa2_in;
         sqb2_ff    <= sqb2_in;
      end
   end

   // ---------------- stage 3: divider setup, compares ----------------
   logic [CW-1:0]        n_re, n_im, lim;
   logic [PW-1:0]        sh_re, sh_im;
   logic                 v3_ff;
   cna_pkg::ctl_type     ctl3_ff, ctl3_in;
   logic [CW-1:0]        rem_re3_ff, rem_im3_ff;
   logic [DW:0]          val_re3_ff, val_im3_ff, val_re3_in, val_im3_in;
   logic [PW-1:0]        d3_ff, srem3_ff;

   always_comb begin
      n_re  = CW'(mag_re2_ff) << F;
      n_im  = CW'(mag_im2_ff) << F;
      lim   = CW'(sqb2_ff) << (DW + 1);
      sh_re = mag_re2_ff >> F;
      sh_im = mag_im2_ff >> F;

      ctl3_in.op     = op2_ff;
      ctl3_in.neg_re = neg_re2_ff;
      ctl3_in.neg_im = neg_im2_ff;
      ctl3_in.dz     = (sqb2_ff == '0);
      unique case (op2_ff)
         cna_pkg::OP_DIV: begin
            // quotient needs more than DW+1 bits: certain clamp
            ctl3_in.huge_re = (n_re >= lim);
            ctl3_in.huge_im = (n_im >= lim);
            val_re3_in      = '0;
            val_im3_in      = '0;
         end
         cna_pkg::OP_MUL: begin
            ctl3_in.huge_re = |sh_re[PW-1:DW+1];
            ctl3_in.huge_im = |sh_im[PW-1:DW+1];
            val_re3_in      = sh_re[DW:0];
            val_im3_in      = sh_im[DW:0];
         end
         default: begin
            ctl3_in.huge_re = 1'b0;
            ctl3_in.huge_im = 1'b0;
            val_re3_in      = mag_re2_ff[DW:0];
            val_im3_in      = mag_im2_ff[DW:0];
         end
      endcase
      unique case (op2_ff)
         cna_pkg::OP_LT: ctl3_in.cmp = (sqa2_ff <  sqb2_ff);
         cna_pkg::OP_LE: ctl3_in.cmp = (sqa2_ff <= sqb2_ff);
         cna_pkg::OP_GT: ctl3_in.cmp = (sqa2_ff >  sqb2_ff);
         cna_pkg::OP_GE: ctl3_in.cmp = (sqa2_ff >= sqb2_ff);
         cna_pkg::OP_EQ: ctl3_in.cmp = eq2_ff;
         cna_pkg::OP_NE: ctl3_in.cmp = !eq2_ff;
         default:        ctl3_in.cmp = 1'b0;
      endcase
   end

   assign en3 = !v3_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         ctl3_ff    <= ctl3_in;
         rem_re3_ff <= n_re;
         rem_im3_ff <= n_im;
         val_re3_ff <= val_re3_in;
         val_im3_ff <= val_im3_in;
         d3_ff      <= sqb2_ff;
         srem3_ff   <= sqa2_ff;
      end
   end

   assign out_valid  = v3_ff;
   assign out_ctl    = ctl3_ff;
   assign out_rem_re = rem_re3_ff;
   assign out_rem_im = rem_im3_ff;
   assign out_val_re = val_re3_ff;
   assign out_val_im = val_im3_ff;
   assign out_d      = d3_ff;
   assign out_srem   = srem3_ff;

endmodule

[src/cna_step.sv]
// One pipeline stage of the shared iteration: one restoring-divide quotient bit
// for each component and, when STEP < DW, one square-root bit. Depends on cna_pkg.
module cna_step #(
   parameter int DW   = 32,
   parameter int F    = 16,
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  cna_pkg::ctl_type     in_ctl,
   input  logic [2*DW+F+DW+1:0] in_rem_re,
   input  logic [2*DW+F+DW+1:0] in_rem_im,
   input  logic [DW:0]          in_val_re,
   input  logic [DW:0]          in_val_im,
   input  logic [2*DW-1:0]      in_d,
   input  logic [2*DW-1:0]      in_srem,
   input  logic [DW-1:0]        in_root,
   output logic                 out_valid,
   input  logic                 out_ready,
   output cna_pkg::ctl_type     out_ctl,
   output logic [2*DW+F+DW+1:0] out_rem_re,
   output logic [2*DW+F+DW+1:0] out_rem_im,
   output logic [DW:0]          out_val_re,
   output logic [DW:0]          out_val_im,
   output logic [2*DW-1:0]      out_d,
   output logic [2*DW-1:0]      out_srem,
   output logic [DW-1:0]        out_root
);
   localparam int PW = 2 * DW;
   localparam int CW = PW + F + DW + 2;

   logic                 en;
   logic                 is_div;
   logic [CW-1:0]        dsh;
   logic                 ge_re, ge_im;
   logic                 v_ff;
   cna_pkg::ctl_type     ctl_ff;
   logic [CW-1:0]        rem_re_ff, rem_im_ff, rem_re_in, rem_im_in;
   logic [DW:0]          val_re_ff, val_im_ff, val_re_in, val_im_in;
   logic [PW-1:0]        d_ff, srem_ff, srem_in;
   logic [DW-1:0]        root_ff, root_in;

   assign is_div = (in_ctl.op == cna_pkg::OP_DIV);
   assign dsh    = CW'(in_d) << STEP;
   assign ge_re  = (in_rem_re >= dsh);
   assign ge_im  = (in_rem_im >= dsh);

   always_comb begin
      rem_re_in = ge_re ? (in_rem_re - dsh) : in_rem_re;
      rem_im_in = ge_im ? (in_rem_im - dsh) : in_rem_im;
      val_re_in = in_val_re;
      val_im_in = in_val_im;
      if (is_div) begin
         val_re_in[STEP] = ge_re;
         val_im_in[STEP] = ge_im;
      end
   end

   generate
      if (STEP < DW) begin : g_sqrt
         logic [PW:0] trial;
         logic        ge_sq;
         // (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
         assign trial = ((PW+1)'(in_root) << (STEP + 1)) + ((PW+1)'(1) << (2 * STEP));
         assign ge_sq = ((PW+1)'(in_srem) >= trial);
         always_comb begin
            srem_in = ge_sq ? (in_srem - trial[PW-1:0]) : in_srem;
            root_in = in_root;
            root_in[STEP] = ge_sq;
         end
      end else begin : g_no_sqrt
         always_comb begin
            srem_in = in_srem;
            root_in = in_root;
         end
      end
   endgenerate

   assign en       = !v_ff || out_ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff    <= in_ctl;
         rem_re_ff <= rem_re_in;
         rem_im_ff <= rem_im_in;
         val_re_ff <= val_re_in;
         val_im_ff <= val_im_in;
         d_ff      <= in_d;
         srem_ff   <= srem_in;
         root_ff   <= root_in;
      end
   end

   assign out_valid  = v_ff;
   assign out_ctl    = ctl_ff;
   assign out_rem_re = rem_re_ff;
   assign out_rem_im = rem_im_ff;
   assign out_val_re = val_re_ff;
   assign out_val_im = val_im_ff;
   assign out_d      = d_ff;
   assign out_srem   = srem_ff;
   assign out_root   = root_ff;

endmodule

[src/cna_back.sv]
// Output stage of the complex ALU: saturation, result selection per operation
// and the response register. Depends on cna_pkg, cna_rsp_if.
module cna_back #(
   parameter int DW = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  cna_pkg::ctl_type in_ctl,
   input  logic [DW:0]      in_val_re,
   input  logic [DW:0]      in_val_im,
   input  logic [DW-1:0]    in_root,
   cna_rsp_if.source        rsp
);
   localparam logic [DW:0] POS_MAX = (DW+1)'((64'd1 << (DW - 1)) - 64'd1);
   localparam logic [DW:0] NEG_MAX = (DW+1)'(64'd1 << (DW - 1));

   // returns {clamped, value}
   function automatic logic [DW:0] clamp(input logic neg, input logic huge,
                                         input logic [DW:0] v);
      logic [DW:0] nv;
      logic        sat;
      logic [DW-1:0] r;
      nv = -v;
      if (!neg) begin
         sat = huge || (v > POS_MAX);
         r   = sat ? POS_MAX[DW-1:0] : v[DW-1:0];
      end else begin
         sat = huge || (v > NEG_MAX);
         r   = sat ? NEG_MAX[DW-1:0] : nv[DW-1:0];
      end
      return {sat, r};
   endfunction

   logic                          en;
   logic [DW:0]                   c_re, c_im;
   logic                          v_ff;
   logic signed [cna_pkg::FIELD_W-1:0] res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic [cna_pkg::FIELD_W-1:0]   mag_ff, mag_in;
   logic                          cmp_ff, cmp_in, dz_ff, dz_in, sat_ff, sat_in;

   assign c_re = clamp(in_ctl.neg_re, in_ctl.huge_re, in_val_re);
   assign c_im = clamp(in_ctl.neg_im, in_ctl.huge_im, in_val_im);

   always_comb begin
      res_re_in = '0;
      res_im_in = '0;
      mag_in    = '0;
      cmp_in    = 1'b0;
      dz_in     = 1'b0;
      sat_in    = 1'b0;
      unique case (in_ctl.op)
         cna_pkg::OP_ADD, cna_pkg::OP_SUB, cna_pkg::OP_MUL, cna_pkg::OP_DIV: begin
            if (in_ctl.op == cna_pkg::OP_DIV && in_ctl.dz) begin
               dz_in = 1'b1;
            end else begin
               res_re_in = cna_pkg::FIELD_W'($signed(c_re[DW-1:0]));
               res_im_in = cna_pkg::FIELD_W'($signed(c_im[DW-1:0]));
               sat_in    = c_re[DW] | c_im[DW];
            end
         end
         cna_pkg::OP_MAG: begin
            mag_in = cna_pkg::FIELD_W'(in_root);
         end
         cna_pkg::OP_LT, cna_pkg::OP_LE, cna_pkg::OP_GT, cna_pkg::OP_GE,
         cna_pkg::OP_EQ, cna_pkg::OP_NE: begin
            cmp_in = in_ctl.cmp;
         end
         default: begin
            cmp_in = 1'b0;
         end
      endcase
   end

   assign en       = !v_ff || rsp.ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         mag_ff    <= mag_in;
         cmp_ff    <= cmp_in;
         dz_ff     <= dz_in;
         sat_ff    <= sat_in;
      end
   end

   assign rsp.valid          = v_ff;
   assign rsp.res_re         = res_re_ff;
   assign rsp.res_im         = res_im_ff;
   assign rsp.magnitude      = mag_ff;
   assign rsp.compare_true   = cmp_ff;
   assign rsp.divide_by_zero = dz_ff;
   assign rsp.saturated      = sat_ff;

endmodule

[src/complex_number_alu.sv]
// Complex ALU top level. Pipeline: DATA_WIDTH + 5 register stages: three front stages,
// DATA_WIDTH + 1 divider/square-root stages (one quotient bit each, and one root bit in
// each but the first), one output stage.
// Throughput: one item per cycle; each stage holds its item while the next is full.
// Reset (synchronous) clears only the stage valid bits.
`include "assert_macros.svh"

module complex_number_alu #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   cna_req_if.sink   req_ch,
   cna_rsp_if.source rsp_ch
);
   localparam int DW = DATA_WIDTH;
   localparam int PW = 2 * DW;
   localparam int CW = PW + FRAC_BITS + DW + 2;
   localparam int NS = DW + 1;

   logic             st_valid [0:NS];
   logic             st_ready [0:NS];
   cna_pkg::ctl_type st_ctl   [0:NS];
   logic [CW-1:0]    st_rem_re[0:NS];
   logic [CW-1:0]    st_rem_im[0:NS];
   logic [DW:0]      st_val_re[0:NS];
   logic [DW:0]      st_val_im[0:NS];
   logic [PW-1:0]    st_d     [0:NS];
   logic [PW-1:0]    st_srem  [0:NS];
   logic [DW-1:0]    st_root  [0:NS];
   logic             res_zero;
   logic             cmp_clean;

   cna_front #(.DW(DW), .F(FRAC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .out_valid  (st_valid[0]),
      .out_ready  (st_ready[0]),
      .out_ctl    (st_ctl[0]),
      .out_rem_re (st_rem_re[0]),
      .out_rem_im (st_rem_im[0]),
      .out_val_re (st_val_re[0]),
      .out_val_im (st_val_im[0]),
      .out_d      (st_d[0]),
      .out_srem   (st_srem[0])
   );

   assign st_root[0] = '0;

   generate
      for (genvar k = 0; k < NS; k++) begin : g_step
         cna_step #(.DW(DW), .F(FRAC_BITS), .STEP(DW - k)) u_step (
            .clock      (clock),
            .reset      (reset),
            .in_valid   (st_valid[k]),
            .in_ready   (st_ready[k]),
            .in_ctl     (st_ctl[k]),
            .in_rem_re  (st_rem_re[k]),
            .in_rem_im  (st_rem_im[k]),
            .in_val_re  (st_val_re[k]),
            .in_val_im  (st_val_im[k]),
            .in_d       (st_d[k]),
            .in_srem    (st_srem[k]),
            .in_root    (st_root[k]),
            .out_valid  (st_valid[k+1]),
            .out_ready  (st_ready[k+1]),
            .out_ctl    (st_ctl[k+1]),
            .out_rem_re (st_rem_re[k+1]),
            .out_rem_im (st_rem_im[k+1]),
            .out_val_re (st_val_re[k+1]),
            .out_val_im (st_val_im[k+1]),
            .out_d      (st_d[k+1]),
            .out_srem   (st_srem[k+1]),
            .out_root   (st_root[k+1])
         );
      end
   endgenerate

   cna_back #(.DW(DW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st_valid[NS]),
      .in_ready  (st_ready[NS]),
      .in_ctl    (st_ctl[NS]),
      .in_val_re (st_val_re[NS]),
      .in_val_im (st_val_im[NS]),
      .in_root   (st_root[NS]),
      .rsp       (rsp_ch)
   );

   assign res_zero  = (rsp_ch.res_re == '0) && (rsp_ch.res_im == '0);
   assign cmp_clean = !rsp_ch.saturated && (rsp_ch.magnitude == '0);

   // input side only backs up when the output register is blocked
   `ASSERT_CLK(a_ready_stall, clock, reset, !req_ch.ready |-> (rsp_ch.valid && !rsp_ch.ready))
   `ASSERT_CLK(a_dz_zero, clock, reset, (rsp_ch.valid && rsp_ch.divide_by_zero) |-> res_zero)
   `ASSERT_NEVER_BOTH(a_dz_sat, clock, reset, rsp_ch.divide_by_zero, rsp_ch.saturated)
   `ASSERT_CLK(a_cmp_clean, clock, reset, (rsp_ch.valid && rsp_ch.compare_true) |-> cmp_clean)

endmodule

[verif/complex_number_alu_tb.sv]
// Self-checking testbench for complex_number_alu: directed and random items with random
// idling and long result back-pressure. Depends on the DUT, cna_pkg and both channel interfaces.
`timescale 1ns / 1ps

module complex_number_alu_tb;

   localparam int DW        = 32;
   localparam int FB        = 16;
   localparam int LATENCY   = DW + 5;
   localparam int IDLE_LIMIT = 4000;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic signed [31:0] res_re;
      logic signed [31:0] res_im;
      logic [31:0]        magnitude;
      logic               compare_true;
      logic               divide_by_zero;
      logic               saturated;
   } alu_result_type;

   logic clock;
   logic reset;
   cna_req_if req ();
   cna_rsp_if rsp ();

   complex_number_alu #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req),
      .rsp_ch(rsp)
   );

   alu_result_type expected_results[$];
   int          error_count = 0;
   bit          idle_en     = 1;
   int          hold_seq    = 0;
   int          hold_seen   = 0;
   int          hold_cnt    = 0;
   int          stall_cnt   = 0;
   int          quiet_cycles = 0;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // clamp a signed wide value to the result range
   function automatic logic signed [31:0] clamp_q(input wide_type v, inout logic sat);
      wide_type hi, lo;
      hi = (wide_type'(1) <<< (DW - 1)) - 1;
      lo = -(wide_type'(1) <<< (DW - 1));
      if (v > hi) begin
         sat = 1'b1;
         return hi[31:0];
      end
      if (v < lo) begin
         sat = 1'b1;
         return lo[31:0];
      end
      return v[31:0];
   endfunction

   // drop fraction bits, rounding toward zero
   function automatic wide_type trunc_frac(input wide_type v);
      if (v < 0) return -((-v) >>> FB);
      return v >>> FB;
   endfunction

   function automatic wide_type floor_sqrt(input wide_type v);
      wide_type res, bt;
      res = 0;
      bt  = wide_type'(1) <<< 62;
      while (bt > v) bt = bt >>> 2;
      while (bt != 0) begin
         if (v >= res + bt) begin
            v   = v - (res + bt);
            res = (res >>> 1) + bt;
         end else begin
            res = res >>> 1;
         end
         bt = bt >>> 2;
      end
      return res;
   endfunction

   function automatic alu_result_type alu_predict(input cna_pkg::op_type op,
                                                  input logic signed [31:0] a_re, a_im,
                                                  input logic signed [31:0] b_re, b_im);
      alu_result_type r;
      wide_type ar, ai, br, bi, sa, sb, n, d, q;
      logic sat;
      ar = a_re; ai = a_im; br = b_re; bi = b_im;
      r = '{default: '0};
      sat = 1'b0;
      sa = ar * ar + ai * ai;
      sb = br * br + bi * bi;
      case (op)
         cna_pkg::OP_ADD: begin
            r.res_re = clamp_q(ar + br, sat);
            r.res_im = clamp_q(ai + bi, sat);
         end
         cna_pkg::OP_SUB: begin
            r.res_re = clamp_q(ar - br, sat);
            r.res_im = clamp_q(ai - bi, sat);
         end
         cna_pkg::OP_MUL: begin
            r.res_re = clamp_q(trunc_frac(ar * br - ai * bi), sat);
            r.res_im = clamp_q(trunc_frac(ar * bi + br * ai), sat);
         end
         cna_pkg::OP_DIV: begin
            d = sb;
            if (d == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               n = ar * br + ai * bi;
               q = ((n < 0 ? -n : n) <<< FB) / d;
               r.res_re = clamp_q(n < 0 ? -q : q, sat);
               n = br * ai - ar * bi;
               q = ((n < 0 ? -n : n) <<< FB) / d;
               r.res_im = clamp_q(n < 0 ? -q : q, sat);
            end
         end
         cna_pkg::OP_MAG: begin
            q = floor_sqrt(sa);
            if (q > (wide_type'(1) <<< DW) - 1) begin
               q = (wide_type'(1) <<< DW) - 1;
               sat = 1'b1;
            end
            r.magnitude = q[31:0];
         end
         cna_pkg::OP_LT: r.compare_true = sa < sb;
         cna_pkg::OP_LE: r.compare_true = sa <= sb;
         cna_pkg::OP_GT: r.compare_true = sa > sb;
         cna_pkg::OP_GE: r.compare_true = sa >= sb;
         cna_pkg::OP_EQ: r.compare_true = (ar == br) && (ai == bi);
         cna_pkg::OP_NE: r.compare_true = !((ar == br) && (ai == bi));
         default: ;
      endcase
      r.saturated = sat;
      return r;
   endfunction

   // record expectation for every accepted request
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         expected_results.push_back(alu_predict(req.operation, req.a_re, req.a_im,
                                                req.b_re, req.b_im));
   end

   always @(posedge clock) begin
      alu_result_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_results.size() == 0) begin
            $error("result item with no expectation pending");
            error_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp.res_re !== e.res_re) begin
               $error("res_re expected %h actual %h", e.res_re, rsp.res_re);
               error_count++;
            end
            if (rsp.res_im !== e.res_im) begin
               $error("res_im expected %h actual %h", e.res_im, rsp.res_im);
               error_count++;
            end
            if (rsp.magnitude !== e.magnitude) begin
               $error("magnitude expected %h actual %h", e.magnitude, rsp.magnitude);
               error_count++;
            end
            if (rsp.compare_true !== e.compare_true) begin
               $error("compare_true expected %b actual %b", e.compare_true,
                      rsp.compare_true);
               error_count++;
            end
            if (rsp.divide_by_zero !== e.divide_by_zero) begin
               $error("divide_by_zero expected %b actual %b", e.divide_by_zero,
                      rsp.divide_by_zero);
               error_count++;
            end
            if (rsp.saturated !== e.saturated) begin
               $error("saturated expected %b actual %b", e.saturated, rsp.saturated);
               error_count++;
            end
         end
      end
   end

   // result side ready: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_cnt  <= 120;
         rsp.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt  <= hold_cnt - 1;
         rsp.ready <= 1'b0;
      end else if (stall_cnt > 0) begin
         stall_cnt <= stall_cnt - 1;
         rsp.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
         stall_cnt <= $urandom_range(0, 4);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("[complex_number_alu] ERROR");
         $finish;
      end
   end

   task automatic send_item(input cna_pkg::op_type op, input logic signed [31:0] a_re, a_im,
                            input logic signed [31:0] b_re, b_im);
      int gap;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.operation <= op;
      req.a_re      <= a_re;
      req.a_im      <= a_im;
      req.b_re      <= b_re;
      req.b_im      <= b_im;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3, 4: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic cna_pkg::op_type rand_op();
      if ($urandom_range(0, 19) == 0) return cna_pkg::op_type'($urandom_range(11, 15));
      return cna_pkg::op_type'($urandom_range(cna_pkg::OP_ADD, cna_pkg::OP_NE));
   endfunction

   task automatic send_random(input int count);
      logic signed [31:0] ar, ai, br, bi;
      cna_pkg::op_type op;
      repeat (count) begin
         op = rand_op();
         ar = rand_operand(); ai = rand_operand();
         br = rand_operand(); bi = rand_operand();
         // give equality and the inclusive ordering compares (LE, GE) a fair share of ties
         if (op inside {cna_pkg::OP_EQ, cna_pkg::OP_NE, cna_pkg::OP_LE, cna_pkg::OP_GE} &&
             $urandom_range(0, 2) == 0) begin
            br = ar; bi = ai;
         end
         if (op == cna_pkg::OP_DIV && $urandom_range(0, 9) == 0) begin
            br = '0; bi = '0;
         end
         send_item(op, ar, ai, br, bi);
      end
   endtask

   task automatic test_directed();
      logic signed [31:0] mx, mn, one;
      mx = 32'sh7fff_ffff; mn = 32'sh8000_0000; one = 32'sh0001_0000;
      send_item(cna_pkg::OP_ADD, mx, mn, mx, mn);
      send_item(cna_pkg::OP_ADD, one, -one, one, one);
      send_item(cna_pkg::OP_SUB, mn, mx, mx, mn);
      send_item(cna_pkg::OP_SUB, one, 0, 0, one);
      send_item(cna_pkg::OP_MUL, mn, mn, mn, mn);
      send_item(cna_pkg::OP_MUL, one, one, one, -one);
      send_item(cna_pkg::OP_MUL, -1, 0, 1, 0);
      send_item(cna_pkg::OP_DIV, one, one, 0, 0);
      send_item(cna_pkg::OP_DIV, mx, mn, 1, 0);
      send_item(cna_pkg::OP_DIV, one, 0, 3 * one, 0);
      send_item(cna_pkg::OP_DIV, -one, one, one, one);
      send_item(cna_pkg::OP_MAG, mn, mn, 0, 0);
      send_item(cna_pkg::OP_MAG, 3 * one, 4 * one, 0, 0);
      send_item(cna_pkg::OP_MAG, 0, 0, 0, 0);
      send_item(cna_pkg::OP_LT, one, 0, 0, one);
      send_item(cna_pkg::OP_LE, one, 0, 0, -one);
      send_item(cna_pkg::OP_GT, mn, 0, mx, 0);
      send_item(cna_pkg::OP_GE, 0, 0, 0, 0);
      send_item(cna_pkg::OP_EQ, one, mn, one, mn);
      send_item(cna_pkg::OP_EQ, one, mn, one, mx);
      send_item(cna_pkg::OP_NE, mx, mx, mx, mx);
      send_item(cna_pkg::OP_NE, 0, 1, 0, 0);
      send_item(cna_pkg::op_type'(11), mx, mx, mx, mx);
      send_item(cna_pkg::op_type'(15), mn, mn, mn, mn);
   endtask

   task automatic test_random_mix();
      send_random(450);
   endtask

   task automatic test_backpressure();
      hold_seq++;
      send_random(150);
   endtask

   task automatic test_quiet_stream();
      idle_en = 0;
      send_random(100);
   endtask

   initial begin
      int waited;
      reset         <= 1'b1;
      req.valid     <= 1'b0;
      req.operation <= cna_pkg::OP_ADD;
      req.a_re      <= '0;
      req.a_im      <= '0;
      req.b_re      <= '0;
      req.b_im      <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_mix();
      test_backpressure();
      test_quiet_stream();
      req.valid <= 1'b0;

      waited = 0;
      while (expected_results.size() != 0 && waited < 20 * IDLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("[complex_number_alu] OK");
      end else begin
         $display("[complex_number_alu] ERROR");
      end
      $finish;
   end

endmodule
